### src/vmx_pkg.sv
// vmx_pkg: shared types, constants and byte-template function for the translator
// no dependencies
package vmx_pkg;

  localparam int NumRegs  = 7;
  localparam int MaxBytes = 38;
  localparam int PosW     = 6;
  localparam int RegIdxW  = 3;
  localparam int FifoDepth = 2;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,  OP_SLOAD = 4'd1,  OP_SSTORE = 4'd2, OP_ADD  = 4'd3,
    OP_MUL   = 4'd4,  OP_DIV   = 4'd5,  OP_NAND   = 4'd6, OP_HALT = 4'd7,
    OP_MAP   = 4'd8,  OP_UNMAP = 4'd9,  OP_OUT    = 4'd10, OP_IN  = 4'd11,
    OP_LPROG = 4'd12, OP_LVAL  = 4'd13, OP_BAD14  = 4'd14, OP_BAD15 = 4'd15
  } opcode_t;

  // classified instruction handed from front to back
  typedef struct packed {
    opcode_t     op;
    logic [27:0] body;   // bits 27..0 of the word
    logic [PosW-1:0] len;
    logic        halt;
  } decoded_t;

  // byte kind returned by the template: literal byte or address byte k
  typedef struct packed {
    logic       is_addr;
    logic [2:0] addr_k;
    logic [7:0] lit;
  } tbyte_t;

  function automatic tbyte_t lit_b(input logic [7:0] v);
    tbyte_t t;
    t.is_addr = 1'b0;
    t.addr_k  = 3'd0;
    t.lit     = v;
    return t;
  endfunction

  // fragment length of each opcode, ret included
  function automatic logic [PosW-1:0] frag_len(input opcode_t op);
    logic [PosW-1:0] n;
    unique case (op)
      OP_LVAL:  n = 6'd8;
      OP_SLOAD: n = 6'd30;
      OP_SSTORE: n = 6'd38;
      OP_NAND:  n = 6'd16;
      OP_LPROG: n = 6'd35;
      OP_ADD:   n = 6'd13;
      OP_CMOV:  n = 6'd10;
      OP_MAP:   n = 6'd35;
      OP_UNMAP: n = 6'd32;
      OP_DIV:   n = 6'd19;
      OP_MUL:   n = 6'd16;
      OP_OUT:   n = 6'd24;
      OP_IN:    n = 6'd24;
      default:  n = 6'd1;
    endcase
    return n;
  endfunction

  // push/call/pop helper section starting at offset p: cnt regs
  function automatic tbyte_t call_seq(input logic [PosW-1:0] p, input logic [2:0] cnt);
    tbyte_t t;
    logic [PosW-1:0] pe;
    logic [PosW-1:0] q;
    logic [PosW-1:0] r;
    pe = {2'b00, cnt, 1'b0};
    t = lit_b(8'h00);
    if (p < pe) begin
      t = p[0] ? lit_b(8'h50 + {5'd0, p[3:1]}) : lit_b(8'h41);
    end else if (p < pe + 6'd12) begin
      q = p - pe;
      if (q == 6'd0) t = lit_b(8'h48);
      else if (q == 6'd1) t = lit_b(8'hb8);
      else if (q == 6'd10) t = lit_b(8'hff);
      else if (q == 6'd11) t = lit_b(8'hd0);
      else begin
        t.is_addr = 1'b1;
        t.addr_k  = 3'(q - 6'd2);
        t.lit     = 8'h00;
      end
    end else begin
      r = p - pe - 6'd12;
      t = r[0] ? lit_b(8'h58 + 8'(cnt - 3'd1 - r[3:1])) : lit_b(8'h41);
    end
    return t;
  endfunction

  function automatic logic [7:0] pick3(input logic [1:0] k, input logic [7:0] x,
                                       input logic [7:0] y, input logic [7:0] z);
    logic [7:0] v;
    unique case (k)
      2'd0: v = x;
      2'd1: v = y;
      default: v = z;
    endcase
    return v;
  endfunction

  // byte of the template at position p (excluding final ret)
  function automatic tbyte_t tmpl(input opcode_t op, input logic [27:0] bd,
                                  input logic [PosW-1:0] p);
    tbyte_t t;
    logic [2:0] a, b, c, r;
    logic [7:0] ab, bb, cb;
    logic [24:0] v;
    logic [1:0] k;
    logic [PosW-1:0] g;
    logic [11:0] gm;
    a = bd[8:6]; b = bd[5:3]; c = bd[2:0]; r = bd[27:25]; v = bd[24:0];
    ab = {5'd0, a}; bb = {2'd0, b, 3'd0}; cb = {2'd0, c, 3'd0};
    // group of three and slot in it: p * 43 / 128 is exact p / 3 below 64
    gm = {6'd0, p} * 12'd43;
    g = {1'b0, gm[11:7]};
    k = 2'(p - (g + {g[4:0], 1'b0}));
    t = lit_b(8'hc3);
    unique case (op)
      OP_LVAL: begin
        if (p < 6'd3) t = lit_b(pick3(k, 8'h41, 8'hc7, 8'hc0 | {5'd0, r}));
        else if (p < 6'd7) t = lit_b(8'(v >> (8 * (p - 6'd3))));
      end
      OP_SLOAD: begin
        if (p < 6'd6) t = lit_b(pick3(k, 8'h44, 8'h89, (g == 6'd0) ? (8'hc7 | bb) : (8'hc6 | cb)));
        else if (p < 6'd26) t = call_seq(p - 6'd6, 3'd2);
        else if (p < 6'd29) t = lit_b(pick3(2'(p - 6'd26), 8'h41, 8'h89, 8'hc0 | ab));
      end
      OP_SSTORE: begin
        if (p < 6'd9) t = lit_b(pick3(k, 8'h44, 8'h89, (g == 6'd0) ? (8'hc7 | {2'd0, a, 3'd0}) :
                                  (g == 6'd1) ? (8'hc6 | bb) : (8'hc2 | cb)));
        else if (p < 6'd37) t = call_seq(p - 6'd9, 3'd4);
      end
      OP_NAND: begin
        if (p < 6'd15) unique case (g)
          6'd0: t = lit_b(pick3(k, 8'h48, 8'h31, 8'hc0));
          6'd1: t = lit_b(pick3(k, 8'h44, 8'h89, 8'hc0 | bb));
          6'd2: t = lit_b(pick3(k, 8'h44, 8'h21, 8'hc0 | cb));
          6'd3: t = lit_b(pick3(k, 8'h40, 8'hf7, 8'hd0));
          default: t = lit_b(pick3(k, 8'h41, 8'h89, 8'hc0 | ab));
        endcase
      end
      OP_LPROG: begin
        if (p < 6'd6) t = lit_b(pick3(k, 8'h44, 8'h89, (g == 6'd0) ? (8'hc7 | bb) : (8'hc6 | cb)));
        else if (p < 6'd34) t = call_seq(p - 6'd6, 3'd4);
      end
      OP_ADD: begin
        if (p < 6'd12) unique case (g)
          6'd0: t = lit_b(pick3(k, 8'h48, 8'h31, 8'hc0));
          6'd1: t = lit_b(pick3(k, 8'h44, 8'h89, 8'hc0 | bb));
          6'd2: t = lit_b(pick3(k, 8'h44, 8'h01, 8'hc0 | cb));
          default: t = lit_b(pick3(k, 8'h41, 8'h89, 8'hc0 | ab));
        endcase
      end
      OP_CMOV: begin
        if (p < 6'd9) unique case (g)
          6'd0: t = lit_b(pick3(k, 8'h41, 8'h83, 8'hF8 | {5'd0, c}));
          6'd1: t = lit_b(pick3(k, 8'h00, 8'h74, 8'h03));
          default: t = lit_b(pick3(k, 8'h45, 8'h89, 8'hc0 | bb | ab));
        endcase
      end
      OP_MAP: begin
        if (p < 6'd3) t = lit_b(pick3(k, 8'h44, 8'h89, 8'hc7 | cb));
        else if (p < 6'd31) t = call_seq(p - 6'd3, 3'd4);
        else if (p < 6'd34) t = lit_b(pick3(2'(p - 6'd31), 8'h41, 8'h89, 8'hc0 | {5'd0, b}));
      end
      OP_UNMAP: begin
        if (p < 6'd3) t = lit_b(pick3(k, 8'h44, 8'h89, 8'hc7 | cb));
        else if (p < 6'd31) t = call_seq(p - 6'd3, 3'd4);
      end
      OP_DIV: begin
        if (p < 6'd18) unique case (g)
          6'd0, 6'd5: t = lit_b(pick3(k, 8'h48, 8'h31, 8'hc0));
          6'd1: t = lit_b(pick3(k, 8'h48, 8'h31, 8'hD2));
          6'd2: t = lit_b(pick3(k, 8'h44, 8'h89, 8'hC0 | bb));
          6'd3: t = lit_b(pick3(k, 8'h49, 8'hF7, 8'hF0 | {5'd0, c}));
          default: t = lit_b(pick3(k, 8'h49, 8'h89, 8'hC0 | ab));
        endcase
      end
      OP_MUL: begin
        if (p < 6'd15) unique case (g)
          6'd0, 6'd4: t = lit_b(pick3(k, 8'h48, 8'h31, 8'hc0));
          6'd1: t = lit_b(pick3(k, 8'h44, 8'h89, 8'hC0 | bb));
          6'd2: t = lit_b(pick3(k, 8'h41, 8'hF7, 8'hE0 | {5'd0, c}));
          default: t = lit_b(pick3(k, 8'h41, 8'h89, 8'hC0 | ab));
        endcase
      end
      OP_OUT: begin
        if (p < 6'd3) t = lit_b(pick3(k, 8'h44, 8'h89, 8'hc7 | cb));
        else if (p < 6'd23) t = call_seq(p - 6'd3, 3'd2);
      end
      OP_IN: begin
        if (p < 6'd20) t = call_seq(p, 3'd2);
        else if (p < 6'd23) t = lit_b(pick3(2'(p - 6'd20), 8'h41, 8'h89, 8'hC0 | {5'd0, c}));
      end
      default: t = lit_b(8'hc3);
    endcase
    return t;
  endfunction

  // helper register used by each opcode
  function automatic logic [RegIdxW-1:0] helper_sel(input opcode_t op);
    logic [RegIdxW-1:0] s;
    unique case (op)
      OP_SLOAD:  s = 3'd0;
      OP_SSTORE: s = 3'd1;
      OP_LPROG:  s = 3'd2;
      OP_MAP:    s = 3'd3;
      OP_UNMAP:  s = 3'd4;
      OP_OUT:    s = 3'd5;
      OP_IN:     s = 3'd6;
      default:   s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

### src/vmx_front.sv
// vmx_front: accepts instruction words, classifies them and queues them
// depends on vmx_pkg
module vmx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         instruction_word,
  output logic                q_valid,
  input  logic                q_take,
  output vmx_pkg::decoded_t   q_data
);

  vmx_pkg::decoded_t fifo [vmx_pkg::FifoDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;
  vmx_pkg::decoded_t dec;

  // classify the incoming word
  always_comb begin
    dec.op   = vmx_pkg::opcode_t'(instruction_word[31:28]);
    dec.body = instruction_word[27:0];
    dec.len  = vmx_pkg::frag_len(dec.op);
    dec.halt = (dec.op == vmx_pkg::OP_HALT) || (dec.op == vmx_pkg::OP_BAD14) ||
               (dec.op == vmx_pkg::OP_BAD15);
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_data  = fifo[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) fifo[wr_ptr] <= dec;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("full while empty");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (full && !do_pop) |=> full)
    else $error("full dropped without pop");

endmodule

### src/vmx_back.sv
// vmx_back: walks each queued instruction's template and emits code bytes
// depends on vmx_pkg
module vmx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_take,
  input  vmx_pkg::decoded_t q_data,
  input  logic [63:0]       helper_addr,
  output logic [vmx_pkg::RegIdxW-1:0] helper_idx,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        code_byte,
  output logic              last_byte,
  output logic              halt
);

  logic [vmx_pkg::PosW-1:0] pos;
  logic       is_last;
  logic       out_valid;
  logic       load;
  vmx_pkg::tbyte_t tb;
  logic [7:0] byte_val;

  assign helper_idx = vmx_pkg::helper_sel(q_data.op);
  assign is_last    = (pos == q_data.len - 6'd1);

  // current template byte
  always_comb begin
    tb = vmx_pkg::tmpl(q_data.op, q_data.body, pos);
    if (is_last) byte_val = 8'hc3;
    else if (tb.is_addr) byte_val = helper_addr[{tb.addr_k, 3'b000} +: 8];
    else byte_val = tb.lit;
  end

  assign load   = q_valid && (!out_valid || pop);
  assign q_take = load && is_last;
  assign empty  = !out_valid;

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      code_byte <= byte_val;
      last_byte <= is_last;
      halt      <= q_data.halt;
    end
  end

  // byte position and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) pos <= is_last ? '0 : pos + 6'd1;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < vmx_pkg::MaxBytes[vmx_pkg::PosW-1:0])
    else $error("position beyond fragment");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> ($stable(code_byte) && out_valid))
    else $error("word changed while stalled");
  a_take_last: assert property (@(posedge clk) disable iff (rst)
    q_take |=> last_byte)
    else $error("entry retired without last byte");

endmodule

### src/vm_instruction_to_x86_translator_top.sv
// vm_instruction_to_x86_translator_top: translator top level
// depends on vmx_pkg, vmx_front, vmx_back
//
// Usage: write helper addresses through cfg_we/cfg_idx/cfg_data (index 0..6,
// others ignored) while idle. Push 32-bit instruction words with push when
// full is low. Each word produces its x86-64 fragment one byte per word on
// the result side: code_byte, last_byte set on the closing ret, halt set on
// every byte of a stop or invalid instruction. Read with pop while empty low.
// A word is first queued, then its first byte is loaded into the output register.
// Throughput: one byte per cycle while pop keeps up and words are queued; an
// instruction occupies the output for its fragment length, 1 to 38 bytes, at a
// pace set by the single-byte output register. A two-entry queue between decode
// and emission keeps accepting words while bytes drain. Reset clears the queue,
// the byte counter and the helper addresses to zero. When the receiver stalls,
// the output word holds and the queue fills; full then rises until bytes move again.
module vm_instruction_to_x86_translator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_word,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  code_byte,
  output logic        last_byte,
  output logic        halt
);

  logic [63:0] helper_regs [vmx_pkg::NumRegs];
  logic        q_valid, q_take;
  vmx_pkg::decoded_t q_data;
  logic [vmx_pkg::RegIdxW-1:0] helper_idx;
  logic [63:0] helper_addr;

  // helper address registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vmx_pkg::NumRegs; i++) helper_regs[i] <= '0;
    end else if (cfg_we && (cfg_idx < 3'(vmx_pkg::NumRegs))) begin
      helper_regs[cfg_idx] <= cfg_data;
    end
  end

  assign helper_addr = (helper_idx < 3'(vmx_pkg::NumRegs)) ? helper_regs[helper_idx] : '0;

  vmx_front u_front (
    .clk, .rst, .push, .full, .instruction_word,
    .q_valid, .q_take, .q_data
  );

  vmx_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_data, .helper_addr, .helper_idx,
    .empty, .pop, .code_byte, .last_byte, .halt
  );

endmodule
